// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked on clk_i, off while rst_ni is low
`define KDVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define KDVE_ASSERT_NEVER(lbl, cond, msg) `KDVE_ASSERT(lbl, !(cond), msg)
`else
`define KDVE_ASSERT(lbl, prop, msg)
`define KDVE_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/kdve_pkg.sv =====
// Types, constants and helpers for the keyed decimal vector entry block
package kdve_pkg;

  localparam int AXES                = 3;
  localparam int OUT_AXES            = 3;
  localparam int MAX_DIGITS          = 12;
  localparam int MAX_FRACTION_DIGITS = 4;

  localparam int OP_W       = 3;
  localparam int DIGIT_W    = 4;
  localparam int CUR_W      = 2;
  localparam int MAG_W      = 40;
  localparam int PLACES_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 2;

  localparam logic [DIGIT_W-1:0]  DIGIT_MAX   = DIGIT_W'(9);
  // 0.0001 shown as magnitude 1 with four fraction digits
  localparam logic [PLACES_W-1:0] ZERO_PLACES = PLACES_W'(4);
  localparam logic [CUR_W-1:0]    AXES_MAX_RST = CUR_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_DIGIT     = 3'd0,
    OP_PERIOD    = 3'd1,
    OP_MINUS     = 3'd2,
    OP_KP_MINUS  = 3'd3,
    OP_BACKSPACE = 3'd4,
    OP_TAB       = 3'd5,
    OP_OTHER     = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXES_MAX        = 3'd0,
    CFG_AFFECT_ALL      = 3'd1,
    CFG_NULL_AS_ONE     = 3'd2,
    CFG_FORBID_ZERO     = 3'd3,
    CFG_FORBID_FRACTION = 3'd4,
    CFG_FORBID_NEGATIVE = 3'd5
  } cfg_idx_e;

  function automatic logic [MAG_W-1:0] pow10(input int n);
    logic [MAG_W-1:0] r;
    r = MAG_W'(1);
    for (int k = 0; k < n; k++) begin
      r = (r << 3) + (r << 1);
    end
    return r;
  endfunction

  // Digits are dropped once the magnitude reaches this bound
  localparam logic [MAG_W-1:0] DIGIT_BOUND = pow10(MAX_DIGITS - 1);
  localparam logic [MAG_W-1:0] MAG_CEIL    = pow10(MAX_DIGITS);

  typedef struct packed {
    logic [CUR_W-1:0] axes_max;
    logic             affect_all;
    logic             null_as_one;
    logic             forbid_zero;
    logic             forbid_fraction;
    logic             forbid_negative;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DIGIT_W-1:0] digit;
    logic               alt_held;
  } key_t;

  typedef struct packed {
    logic                typed;
    logic                negative;
    logic                frac_mode;
    logic [PLACES_W-1:0] frac_digits;
    logic [MAG_W-1:0]    magnitude;
  } axis_t;

  typedef struct packed {
    logic                negative;
    logic [MAG_W-1:0]    magnitude;
    logic [PLACES_W-1:0] places;
  } vec_t;

  typedef struct packed {
    logic                     changed;
    logic                     any_typed;
    logic [CUR_W-1:0]         cursor_axis;
    vec_t [OUT_AXES-1:0]      vec;
  } res_t;

  function automatic logic [CUR_W-1:0] highest_axis(input logic [CUR_W-1:0] axes_max);
    return (axes_max > CUR_W'(AXES - 1)) ? CUR_W'(AXES - 1) : axes_max;
  endfunction

  function automatic logic [MAG_W-1:0] times_ten_plus(input logic [MAG_W-1:0] m,
                                                      input logic [DIGIT_W-1:0] d);
    return (m << 3) + (m << 1) + MAG_W'(d);
  endfunction

endpackage

// ===== design/kdve_key_if.sv =====
// Key event channel: valid/ready plus key payload
interface kdve_key_if;
  import kdve_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [DIGIT_W-1:0] digit;
  logic               alt_held;

  modport source (output valid, op, digit, alt_held, input ready);
  modport sink   (input valid, op, digit, alt_held, output ready);
endinterface

// ===== design/kdve_vec_if.sv =====
// Result channel: valid/ready plus status and applied three-axis vector
interface kdve_vec_if;
  import kdve_pkg::*;

  logic                valid;
  logic                ready;
  logic                changed;
  logic                any_typed;
  logic [CUR_W-1:0]    cursor_axis;
  logic                x_negative;
  logic [MAG_W-1:0]    x_magnitude;
  logic [PLACES_W-1:0] x_places;
  logic                y_negative;
  logic [MAG_W-1:0]    y_magnitude;
  logic [PLACES_W-1:0] y_places;
  logic                z_negative;
  logic [MAG_W-1:0]    z_magnitude;
  logic [PLACES_W-1:0] z_places;

  modport source (output valid, changed, any_typed, cursor_axis,
                  x_negative, x_magnitude, x_places,
                  y_negative, y_magnitude, y_places,
                  z_negative, z_magnitude, z_places,
                  input ready);
  modport sink   (input valid, changed, any_typed, cursor_axis,
                  x_negative, x_magnitude, x_places,
                  y_negative, y_magnitude, y_places,
                  z_negative, z_magnitude, z_places,
                  output ready);
endinterface

// ===== design/kdve_cfg_regs.sv =====
// Configuration registers behind a plain write port
module kdve_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kdve_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kdve_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output kdve_pkg::cfg_t                   cfg_o
);
  import kdve_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AXES_MAX:        cfg_d.axes_max        = cfg_wdata_i[CUR_W-1:0];
        CFG_AFFECT_ALL:      cfg_d.affect_all      = cfg_wdata_i[0];
        CFG_NULL_AS_ONE:     cfg_d.null_as_one     = cfg_wdata_i[0];
        CFG_FORBID_ZERO:     cfg_d.forbid_zero     = cfg_wdata_i[0];
        CFG_FORBID_FRACTION: cfg_d.forbid_fraction = cfg_wdata_i[0];
        CFG_FORBID_NEGATIVE: cfg_d.forbid_negative = cfg_wdata_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{axes_max: AXES_MAX_RST, default: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/kdve_axis_state.sv =====
// Per-axis number state and cursor, with the key-event update logic
`include "assert_macros.svh"

module kdve_axis_state (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    fire_i,
  input  kdve_pkg::key_t                          key_i,
  input  kdve_pkg::cfg_t                          cfg_i,
  output kdve_pkg::axis_t [kdve_pkg::AXES-1:0]    axis_d_o,
  output logic [kdve_pkg::CUR_W-1:0]              cursor_d_o,
  output logic                                    changed_o
);
  import kdve_pkg::*;

  axis_t [AXES-1:0] axis_q, axis_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [CUR_W-1:0] cur;
  logic [CUR_W-1:0] hi;
  logic             cur_typed;
  logic             changed;
  op_e              op;

  assign op = op_e'(key_i.op);

  always_comb begin
    cur       = (cursor_q >= CUR_W'(AXES)) ? '0 : cursor_q;
    hi        = highest_axis(cfg_i.axes_max);
    cur_typed = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (CUR_W'(a) == cur) cur_typed = axis_q[a].typed;
    end

    axis_d   = axis_q;
    cursor_d = cursor_q;
    changed  = 1'b1;

    unique case (op) inside
      OP_DIGIT: begin
        if (key_i.digit > DIGIT_MAX) begin
          changed = 1'b0;
        end else begin
          for (int a = 0; a < AXES; a++) begin
            if (CUR_W'(a) == cur) begin
              if (!axis_q[a].typed) begin
                axis_d[a].typed       = 1'b1;
                axis_d[a].negative    = 1'b0;
                axis_d[a].frac_mode   = 1'b0;
                axis_d[a].frac_digits = '0;
              end
              // saturate: extra digits are swallowed
              if (axis_q[a].magnitude < DIGIT_BOUND) begin
                if (!axis_d[a].frac_mode) begin
                  axis_d[a].magnitude = times_ten_plus(axis_q[a].magnitude, key_i.digit);
                end else if (axis_d[a].frac_digits < PLACES_W'(MAX_FRACTION_DIGITS)) begin
                  axis_d[a].frac_digits = axis_d[a].frac_digits + PLACES_W'(1);
                  axis_d[a].magnitude = times_ten_plus(axis_q[a].magnitude, key_i.digit);
                end
              end
            end
          end
        end
      end
      OP_PERIOD: begin
        if (!cfg_i.forbid_fraction) begin
          for (int a = 0; a < AXES; a++) begin
            if (CUR_W'(a) == cur) begin
              if (!axis_q[a].typed) begin
                axis_d[a].typed       = 1'b1;
                axis_d[a].negative    = 1'b0;
                axis_d[a].frac_digits = '0;
              end
              axis_d[a].frac_mode = 1'b1;
            end
          end
        end
      end
      OP_MINUS, OP_KP_MINUS: begin
        if (!cfg_i.forbid_negative && !(op == OP_KP_MINUS && key_i.alt_held)) begin
          for (int a = 0; a < AXES; a++) begin
            if (CUR_W'(a) == cur) begin
              if (axis_q[a].typed) begin
                axis_d[a].negative = !axis_q[a].negative;
              end else begin
                axis_d[a].typed       = 1'b1;
                axis_d[a].negative    = 1'b1;
                axis_d[a].frac_mode   = 1'b0;
                axis_d[a].frac_digits = '0;
              end
            end
          end
        end
      end
      OP_BACKSPACE: begin
        // untyped cursor axis: wipe everything
        for (int a = 0; a < AXES; a++) begin
          if (!cur_typed || CUR_W'(a) == cur) axis_d[a] = '0;
        end
      end
      OP_TAB: begin
        cursor_d = (cur >= hi) ? '0 : cur + CUR_W'(1);
      end
      default: begin
        changed = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= '0;
      cursor_q <= '0;
    end else if (fire_i) begin
      axis_q   <= axis_d;
      cursor_q <= cursor_d;
    end
  end

  assign axis_d_o   = axis_d;
  assign cursor_d_o = cursor_d;
  assign changed_o  = changed;

  for (genvar g = 0; g < AXES; g++) begin : g_chk
    `KDVE_ASSERT(a_untyped_clean, !axis_q[g].typed |-> (axis_q[g].magnitude == '0 && !axis_q[g].negative && !axis_q[g].frac_mode && axis_q[g].frac_digits == '0), "untyped axis holds data")
    `KDVE_ASSERT(a_frac_bound, (axis_q[g].frac_digits <= PLACES_W'(MAX_FRACTION_DIGITS) && axis_q[g].magnitude < MAG_CEIL), "axis digit count beyond limit")
  end
  `KDVE_ASSERT_NEVER(a_cursor_range, cursor_q > CUR_W'(AXES - 1), "cursor past last axis")

endmodule

// ===== design/kdve_apply.sv =====
// Applied-vector rules: affect-all, null-as-one, no-zero, axes in use
module kdve_apply (
  input  kdve_pkg::axis_t [kdve_pkg::AXES-1:0]  axis_i,
  input  logic [kdve_pkg::CUR_W-1:0]            cursor_i,
  input  logic                                  changed_i,
  input  kdve_pkg::cfg_t                        cfg_i,
  output kdve_pkg::res_t                        res_o
);
  import kdve_pkg::*;

  logic [CUR_W-1:0] hi;
  logic             any;
  axis_t            src;
  res_t             res;

  always_comb begin
    hi  = highest_axis(cfg_i.axes_max);
    any = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (CUR_W'(a) <= hi && axis_i[a].typed) any = 1'b1;
    end

    res             = '0;
    src             = '0;
    res.changed     = changed_i;
    res.any_typed   = any;
    res.cursor_axis = cursor_i;

    for (int j = 0; j < AXES; j++) begin
      if (any && CUR_W'(j) <= hi) begin
        if (cfg_i.affect_all && cursor_i != CUR_W'(j) && !axis_i[j].typed) begin
          src = axis_i[0];
        end else begin
          src = axis_i[j];
        end
        if (!src.typed && cfg_i.null_as_one) begin
          res.vec[j].negative  = 1'b0;
          res.vec[j].magnitude = MAG_W'(1);
          res.vec[j].places    = '0;
        end else if (src.magnitude == '0 && cfg_i.forbid_zero) begin
          res.vec[j].negative  = 1'b0;
          res.vec[j].magnitude = MAG_W'(1);
          res.vec[j].places    = ZERO_PLACES;
        end else begin
          res.vec[j].negative  = src.negative && (src.magnitude != '0);
          res.vec[j].magnitude = src.magnitude;
          res.vec[j].places    = src.frac_digits;
        end
      end
    end
  end

  assign res_o = res;

endmodule

// ===== design/keyed_decimal_vector_entry_top.sv =====
// Keyed decimal vector entry: key events in, status and applied vector out
// Path: a key item is held in the input register, then its result in the result register.
// Throughput: one key item per cycle while the result side is ready; the state update and
//   vector rules settle in one pass between the input register and the result register.
// Reset (rst_ni low, async): cursor 0, all axes untyped and zero, no item
//   held in either register, config back to axes_max 2 and all flags off.
`include "assert_macros.svh"

module keyed_decimal_vector_entry_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kdve_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kdve_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  kdve_key_if.sink                         key_i,
  kdve_vec_if.source                       vec_o
);
  import kdve_pkg::*;

  // Input register stage
  logic  in_valid_q, in_valid_d;
  key_t  key_q;
  // Result register stage
  logic  out_valid_q, out_valid_d;
  res_t  res_q;

  logic  out_free;   // result register can take a new item this cycle
  logic  fire;       // input register item is processed this cycle
  logic  take;       // new key item enters the input register

  cfg_t             cfg;
  axis_t [AXES-1:0] axis_d;
  logic [CUR_W-1:0] cursor_d;
  logic             changed;
  res_t             res_d;

  assign out_free    = !out_valid_q || vec_o.ready;
  assign fire        = in_valid_q && out_free;
  // Input register takes a new item when empty, or when its item moves
  // into the result register in the same cycle.
  assign key_i.ready = !in_valid_q || fire;
  assign take        = key_i.valid && key_i.ready;

  assign in_valid_d  = take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (vec_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q <= '{op: key_i.op, digit: key_i.digit, alt_held: key_i.alt_held};
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  kdve_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Axis state commits on fire; its next value feeds the vector rules
  kdve_axis_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .key_i      (key_q),
    .cfg_i      (cfg),
    .axis_d_o   (axis_d),
    .cursor_d_o (cursor_d),
    .changed_o  (changed)
  );

  kdve_apply u_apply (
    .axis_i    (axis_d),
    .cursor_i  (cursor_d),
    .changed_i (changed),
    .cfg_i     (cfg),
    .res_o     (res_d)
  );

  assign vec_o.valid       = out_valid_q;
  assign vec_o.changed     = res_q.changed;
  assign vec_o.any_typed   = res_q.any_typed;
  assign vec_o.cursor_axis = res_q.cursor_axis;
  assign vec_o.x_negative  = res_q.vec[0].negative;
  assign vec_o.x_magnitude = res_q.vec[0].magnitude;
  assign vec_o.x_places    = res_q.vec[0].places;
  assign vec_o.y_negative  = res_q.vec[1].negative;
  assign vec_o.y_magnitude = res_q.vec[1].magnitude;
  assign vec_o.y_places    = res_q.vec[1].places;
  assign vec_o.z_negative  = res_q.vec[2].negative;
  assign vec_o.z_magnitude = res_q.vec[2].magnitude;
  assign vec_o.z_places    = res_q.vec[2].places;

  `KDVE_ASSERT(a_fire_gives_result, fire |=> out_valid_q, "processed item did not reach result register")
  `KDVE_ASSERT(a_no_input_zero_vec, (out_valid_q && !res_q.any_typed) |-> (res_q.vec == '0), "vector nonzero with no input")
  `KDVE_ASSERT_NEVER(a_neg_zero, out_valid_q && res_q.vec[0].negative && res_q.vec[0].magnitude == '0, "negative zero on axis 0")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for keyed_decimal_vector_entry_top: directed and random key streams vs. a predictor
module tb_top;
  import kdve_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // A digit is dropped once the magnitude reaches 10^(MAX_DIGITS-1)
  localparam logic [MAG_W-1:0] SATURATE_AT = MAG_W'(64'd100_000_000_000);
  // Extra wait after the pipe empties, before touching registers
  localparam int SETTLE_CYCLES = 4;
  localparam int LATE_LIMIT    = 400;
  localparam int PHASES        = 9;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  kdve_key_if key_bus ();
  kdve_vec_if vec_bus ();

  keyed_decimal_vector_entry_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_i       (key_bus),
    .vec_o       (vec_bus)
  );

  // Predictor state: register copy, cursor and per-axis entry
  cfg_t                  settings;
  logic [CUR_W-1:0]      cursor_now;
  axis_t                 axis_state [AXES];

  key_t                  pending_keys [$];
  res_t                  awaited_vectors [$];
  key_t                  key_on_bus;
  res_t                  seen_vec;

  int                    keys_queued;
  int                    keys_taken;
  int                    results_seen;
  int                    mismatches;
  int                    cycles;
  int                    send_gap;
  int                    send_calm;
  int                    recv_gap;
  int                    recv_calm;
  string                 axis_name [OUT_AXES] = '{"x", "y", "z"};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    // cap the log; the count still goes on
    if (mismatches <= 100)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
  endtask

  // Idle length for either side: mostly none, some short, a few long,
  // and now and then a calm stretch with no idling at all
  function automatic int pick_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  // Applies one key to the predicted entry state and returns the vector report
  function automatic res_t apply_key(input key_t k);
    res_t                r;
    int                  c;
    int                  hi;
    int                  src;
    logic                any;
    logic                neg;
    logic [MAG_W-1:0]    mag;
    logic [PLACES_W-1:0] pl;
    r = '0;
    r.changed = 1'b1;
    c = int'(cursor_now);
    hi = (settings.axes_max > CUR_W'(AXES - 1)) ? AXES - 1 : int'(settings.axes_max);
    case (k.op)
      OP_DIGIT: begin
        if (k.digit > DIGIT_MAX) begin
          r.changed = 1'b0;
        end else begin
          if (!axis_state[c].typed) begin
            axis_state[c].typed       = 1'b1;
            axis_state[c].negative    = 1'b0;
            axis_state[c].frac_mode   = 1'b0;
            axis_state[c].frac_digits = '0;
          end
          // saturate: too many digits overall, or the fraction is full
          if (axis_state[c].magnitude < SATURATE_AT &&
              !(axis_state[c].frac_mode &&
                axis_state[c].frac_digits >= PLACES_W'(MAX_FRACTION_DIGITS))) begin
            if (axis_state[c].frac_mode) axis_state[c].frac_digits++;
            axis_state[c].magnitude = axis_state[c].magnitude * MAG_W'(10) + MAG_W'(k.digit);
          end
        end
      end
      OP_PERIOD: begin
        if (!settings.forbid_fraction) begin
          if (!axis_state[c].typed) begin
            axis_state[c].typed       = 1'b1;
            axis_state[c].negative    = 1'b0;
            axis_state[c].frac_digits = '0;
          end
          axis_state[c].frac_mode = 1'b1;
        end
      end
      OP_MINUS, OP_KP_MINUS: begin
        // keypad minus with alt held is swallowed but still recognized
        if (!settings.forbid_negative && !(k.op == OP_KP_MINUS && k.alt_held)) begin
          if (axis_state[c].typed) begin
            axis_state[c].negative = !axis_state[c].negative;
          end else begin
            axis_state[c].typed       = 1'b1;
            axis_state[c].negative    = 1'b1;
            axis_state[c].frac_mode   = 1'b0;
            axis_state[c].frac_digits = '0;
          end
        end
      end
      OP_BACKSPACE: begin
        if (!axis_state[c].typed) begin
          for (int a = 0; a < AXES; a++) axis_state[a] = '0;
        end else begin
          axis_state[c] = '0;
        end
      end
      OP_TAB: begin
        c++;
        if (c > hi) c = 0;
        cursor_now = CUR_W'(c);
      end
      default: r.changed = 1'b0;
    endcase

    any = 1'b0;
    for (int j = 0; j <= hi; j++) if (axis_state[j].typed) any = 1'b1;
    r.any_typed   = any;
    r.cursor_axis = cursor_now;

    // no input at all leaves the whole vector at zero
    if (any) begin
      for (int j = 0; j <= hi && j < OUT_AXES; j++) begin
        src = j;
        if (settings.affect_all && int'(cursor_now) != j && !axis_state[j].typed) src = 0;
        if (!axis_state[src].typed && settings.null_as_one) begin
          neg = 1'b0; mag = MAG_W'(1); pl = '0;
        end else if (axis_state[src].magnitude == '0 && settings.forbid_zero) begin
          // zero shows as 0.0001
          neg = 1'b0; mag = MAG_W'(1); pl = PLACES_W'(4);
        end else begin
          mag = axis_state[src].magnitude;
          pl  = axis_state[src].frac_digits;
          neg = axis_state[src].negative && mag != '0;
        end
        r.vec[j].negative  = neg;
        r.vec[j].magnitude = mag;
        r.vec[j].places    = pl;
      end
    end
    return r;
  endfunction

  // Key driver: holds an item until taken, then idles a random number of cycles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      key_bus.valid <= 1'b0;
    end else begin
      if (key_bus.valid && key_bus.ready) begin
        awaited_vectors.push_back(apply_key(key_on_bus));
        keys_taken++;
      end
      if (!key_bus.valid || key_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          key_bus.valid <= 1'b0;
        end else if (pending_keys.size() != 0) begin
          key_on_bus = pending_keys.pop_front();
          key_bus.valid    <= 1'b1;
          key_bus.op       <= key_on_bus.op;
          key_bus.digit    <= key_on_bus.digit;
          key_bus.alt_held <= key_on_bus.alt_held;
          send_gap = pick_idle(send_calm);
        end else begin
          key_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure, each taken item checked against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      vec_bus.ready <= 1'b0;
    end else begin
      if (vec_bus.valid && vec_bus.ready) begin
        results_seen++;
        seen_vec.changed            = vec_bus.changed;
        seen_vec.any_typed          = vec_bus.any_typed;
        seen_vec.cursor_axis        = vec_bus.cursor_axis;
        seen_vec.vec[0].negative    = vec_bus.x_negative;
        seen_vec.vec[0].magnitude   = vec_bus.x_magnitude;
        seen_vec.vec[0].places      = vec_bus.x_places;
        seen_vec.vec[1].negative    = vec_bus.y_negative;
        seen_vec.vec[1].magnitude   = vec_bus.y_magnitude;
        seen_vec.vec[1].places      = vec_bus.y_places;
        seen_vec.vec[2].negative    = vec_bus.z_negative;
        seen_vec.vec[2].magnitude   = vec_bus.z_magnitude;
        seen_vec.vec[2].places      = vec_bus.z_places;
        if (awaited_vectors.size() == 0) begin
          report_mismatch("unexpected item, pending count", 0, 0);
        end else begin
          res_t want;
          want = awaited_vectors.pop_front();
          if (seen_vec.changed !== want.changed)
            report_mismatch("changed", seen_vec.changed, want.changed);
          if (seen_vec.any_typed !== want.any_typed)
            report_mismatch("any_typed", seen_vec.any_typed, want.any_typed);
          if (seen_vec.cursor_axis !== want.cursor_axis)
            report_mismatch("cursor_axis", seen_vec.cursor_axis, want.cursor_axis);
          for (int j = 0; j < OUT_AXES; j++) begin
            if (seen_vec.vec[j].negative !== want.vec[j].negative)
              report_mismatch({axis_name[j], "_negative"}, seen_vec.vec[j].negative,
                              want.vec[j].negative);
            if (seen_vec.vec[j].magnitude !== want.vec[j].magnitude)
              report_mismatch({axis_name[j], "_magnitude"}, seen_vec.vec[j].magnitude,
                              want.vec[j].magnitude);
            if (seen_vec.vec[j].places !== want.vec[j].places)
              report_mismatch({axis_name[j], "_places"}, seen_vec.vec[j].places,
                              want.vec[j].places);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        vec_bus.ready <= 1'b0;
      end else begin
        vec_bus.ready <= 1'b1;
        recv_gap = pick_idle(recv_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_key(input logic [OP_W-1:0] op, input logic [DIGIT_W-1:0] dig,
                          input logic alt);
    key_t k;
    k.op       = op;
    k.digit    = dig;
    k.alt_held = alt;
    pending_keys.push_back(k);
    keys_queued++;
  endtask

  // Mostly well-formed number entry (sign, digits, period, fraction, tab) with
  // occasional backspaces, bare tabs and noise keys including unused codes
  task automatic queue_random_keys(input int target);
    int made;
    int n;
    int r;
    logic [OP_W-1:0]    nop;
    logic [DIGIT_W-1:0] ndig;
    made = 0;
    while (made < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        if ($urandom_range(0, 3) == 0) begin
          push_key($urandom_range(0, 1) ? OP_MINUS : OP_KP_MINUS, DIGIT_W'($urandom),
                   $urandom_range(0, 3) == 0);
          made++;
        end
        // long runs push the magnitude into saturation
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5);
        repeat (n) push_key(OP_DIGIT, DIGIT_W'($urandom_range(0, 9)), 1'($urandom));
        made += n;
        if ($urandom_range(0, 1)) begin
          push_key(OP_PERIOD, DIGIT_W'($urandom), 1'($urandom));
          n = $urandom_range(0, 6);
          repeat (n) push_key(OP_DIGIT, DIGIT_W'($urandom_range(0, 9)), 1'($urandom));
          made += n + 1;
        end
        if ($urandom_range(0, 5) == 0) begin
          push_key(OP_MINUS, DIGIT_W'($urandom), 1'($urandom));
          made++;
        end
        if ($urandom_range(0, 9) < 6) begin
          push_key(OP_TAB, DIGIT_W'($urandom), 1'($urandom));
          made++;
        end
      end else if (r < 75) begin
        n = $urandom_range(1, 2);
        repeat (n) push_key(OP_BACKSPACE, DIGIT_W'($urandom), 1'($urandom));
        made += n;
      end else if (r < 85) begin
        push_key(OP_TAB, DIGIT_W'($urandom), 1'($urandom));
        made++;
      end else begin
        nop  = OP_W'($urandom);
        ndig = DIGIT_W'($urandom);
        push_key(nop, ndig, 1'($urandom));
        if (nop <= OP_TAB && !(nop == OP_DIGIT && ndig > DIGIT_MAX)) made++;
      end
    end
  endtask

  // Wait until every key is taken and every prediction met, then let the pipe empty
  task automatic settle();
    int waited;
    waited = 0;
    while (keys_taken != keys_queued) @(negedge clk_i);
    while (awaited_vectors.size() != 0 && waited < LATE_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (awaited_vectors.size() != 0) begin
      report_mismatch("items never delivered", awaited_vectors.size(), 0);
      awaited_vectors.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all six registers back to back; flag writes carry a random upper bit
  task automatic write_settings(input cfg_t s);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_AXES_MAX;
    cfg_wdata_i <= s.axes_max;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_AFFECT_ALL;
    cfg_wdata_i <= {1'($urandom), s.affect_all};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_NULL_AS_ONE;
    cfg_wdata_i <= {1'($urandom), s.null_as_one};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FORBID_ZERO;
    cfg_wdata_i <= {1'($urandom), s.forbid_zero};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FORBID_FRACTION;
    cfg_wdata_i <= {1'($urandom), s.forbid_fraction};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FORBID_NEGATIVE;
    cfg_wdata_i <= {1'($urandom), s.forbid_negative};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings = s;
  endtask

  initial begin
    cfg_t s;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_AXES_MAX;
    cfg_wdata_i      = '0;
    key_bus.valid    = 1'b0;
    key_bus.op       = OP_OTHER;
    key_bus.digit    = '0;
    key_bus.alt_held = 1'b0;
    vec_bus.ready    = 1'b0;
    settings         = '0;
    settings.axes_max = AXES_MAX_RST;
    cursor_now       = '0;
    for (int a = 0; a < AXES; a++) axis_state[a] = '0;
    keys_queued = 0; keys_taken = 0; results_seen = 0; mismatches = 0; cycles = 0;
    send_gap = 0; send_calm = 0; recv_gap = 0; recv_calm = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unrecognized keys with nothing typed, digit codes above nine
    push_key(OP_OTHER, 4'd0, 1'b0);
    push_key(OP_W'(7), 4'd15, 1'b1);
    push_key(OP_DIGIT, 4'd10, 1'b0);
    push_key(OP_DIGIT, 4'd15, 1'b1);
    push_key(OP_BACKSPACE, 4'd0, 1'b0);      // clears everything when untyped
    // negative zero must read as plain zero
    push_key(OP_MINUS, 4'd0, 1'b0);
    push_key(OP_DIGIT, 4'd0, 1'b0);
    push_key(OP_DIGIT, 4'd9, 1'b0);
    push_key(OP_PERIOD, 4'd0, 1'b0);
    push_key(OP_PERIOD, 4'd0, 1'b0);         // already in fraction mode
    push_key(OP_DIGIT, 4'd1, 1'b0);
    push_key(OP_DIGIT, 4'd2, 1'b0);
    push_key(OP_DIGIT, 4'd3, 1'b0);
    push_key(OP_DIGIT, 4'd4, 1'b0);
    push_key(OP_DIGIT, 4'd5, 1'b0);          // fraction full, dropped
    push_key(OP_KP_MINUS, 4'd0, 1'b1);       // alt held, swallowed
    push_key(OP_KP_MINUS, 4'd0, 1'b0);
    push_key(OP_TAB, 4'd0, 1'b0);
    push_key(OP_PERIOD, 4'd0, 1'b0);         // untyped axis enters fraction mode
    push_key(OP_TAB, 4'd0, 1'b0);
    push_key(OP_TAB, 4'd0, 1'b0);            // wraps to axis 0
    push_key(OP_BACKSPACE, 4'd0, 1'b0);      // clears only the cursor axis
    push_key(OP_BACKSPACE, 4'd0, 1'b0);
    queue_random_keys(150);
    settle();

    for (int phase = 1; phase < PHASES; phase++) begin
      s = '0;
      case (phase)
        1: s = '1;                            // highest axis beyond range, every flag on
        2: begin s.axes_max = 2'd0; s.affect_all = 1'b1; s.null_as_one = 1'b1; end
        3: begin s.axes_max = 2'd1; s.affect_all = 1'b1; s.forbid_zero = 1'b1; end
        4: begin
          s.axes_max = 2'd2; s.affect_all = 1'b1; s.null_as_one = 1'b1; s.forbid_zero = 1'b1;
        end
        5: begin s.axes_max = 2'd2; s.forbid_fraction = 1'b1; s.forbid_negative = 1'b1; end
        default: s = cfg_t'(6'($urandom_range(0, 63)));
      endcase
      write_settings(s);
      queue_random_keys(160);
      settle();
    end

    $display("checked %0d result items from %0d key items", results_seen, keys_taken);
    $display("register settings exercised: %0d, from reset values to all flags set", PHASES);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== keyed_decimal_vector_entry_top.f =====
+incdir+design
design/kdve_pkg.sv
design/kdve_key_if.sv
design/kdve_vec_if.sv
design/kdve_cfg_regs.sv
design/kdve_axis_state.sv
design/kdve_apply.sv
design/keyed_decimal_vector_entry_top.sv
test/tb_top.sv
